// File: hdl/tsjq_pkg.sv
// Package for the timed sorted job queue: field widths, codes, FSM states
// and the command/status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package tsjq_pkg;

  localparam int DEPTH_DEFAULT     = 16;
  localparam int TIME_BITS_DEFAULT = 16;

  localparam int KIND_W   = 2;
  localparam int START_W  = 16;
  localparam int TAG_W    = 8;
  localparam int POS_W    = 4;
  localparam int STATUS_W = 3;

  // Most jobs released by a single tick.
  localparam int MAX_BURST = 16;
  localparam int BURST_W   = $clog2(MAX_BURST);

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD    = 2'd0,
    KIND_REMOVE = 2'd1,
    KIND_TICK   = 2'd2
  } kind_t;

  typedef enum logic [STATUS_W-1:0] {
    RES_ADDED      = 3'd0,
    RES_REMOVED    = 3'd1,
    RES_DISPATCHED = 3'd2,
    RES_EMPTY      = 3'd3,
    RES_BAD_INDEX  = 3'd4,
    RES_FULL       = 3'd5
  } res_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD,
    S_REMOVE,
    S_TICK,
    S_SCAN
  } state_t;

  typedef struct packed {
    logic latch;      // capture the incoming transaction
    logic add;        // insert entry, load result
    logic remove;     // take out entry at position, load result
    logic advance;    // bump the time counter
    logic pop;        // release head, load result
    logic burst_end;  // this pop is the last one a tick may release
  } dp_cmd_t;

  typedef struct packed {
    logic out_free;   // result register can take a new result this cycle
    logic head_due;   // head entry start time reached
    logic next_due;   // entry behind the head also due
  } dp_stat_t;

endpackage

`default_nettype wire

// File: hdl/tsjq_if.sv
// Valid/ready channel interfaces for the job queue command and result streams.
// Depends on tsjq_pkg for field widths.
`timescale 1ns / 1ps
`default_nettype none

interface tsjq_cmd_if import tsjq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [KIND_W-1:0]   kind;
  logic [START_W-1:0]  start_time;
  logic [TAG_W-1:0]    job_tag;
  logic [POS_W-1:0]    position;

  modport source (output valid, kind, start_time, job_tag, position, input ready);
  modport sink   (input valid, kind, start_time, job_tag, position, output ready);
endinterface

interface tsjq_res_if import tsjq_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status;
  logic [TAG_W-1:0]    out_tag;
  logic [START_W-1:0]  out_start;
  logic [START_W-1:0]  out_submitted;
  logic [START_W-1:0]  now_time;
  logic                last;

  modport source (output valid, status, out_tag, out_start, out_submitted, now_time, last,
                  input ready);
  modport sink   (input valid, status, out_tag, out_start, out_submitted, now_time, last,
                  output ready);
endinterface

`default_nettype wire

// File: hdl/timed_sorted_job_queue.sv
// Timed sorted job queue, top level. Joins the controller FSM and the datapath.
// Depends on tsjq_pkg, tsjq_if, tsjq_ctrl and tsjq_dp.
//
// Usage:
//   cmd channel (valid/ready) carries kind, start_time, job_tag and position.
//   res channel (valid/ready) carries status, out_tag, out_start, out_submitted,
//   now_time and last; last marks the final result of one command.
//   Entries stay sorted by start time, equal times in arrival order.
// Timing:
//   Add and remove: one result per command (capture, then one shift of the
//   entry cell array that also loads the result register). Tick: capture,
//   advance time, then one released job per cycle while the result register
//   is free, up to 16 per tick; a tick with nothing due gives no result and
//   ends after the first look at the head. Commands are taken one at a time.
// Reset (rst, synchronous): queue empty, time counter zero, no result pending.
// Stall: results wait in the output register; while it is held the block
//   still takes one more command but does not load its result until res.ready.
`timescale 1ns / 1ps
`default_nettype none

module timed_sorted_job_queue import tsjq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEPTH_DEFAULT,
  parameter int TIME_BITS   = TIME_BITS_DEFAULT
) (
  input  logic       clk,
  input  logic       rst,
  tsjq_cmd_if.sink   cmd,
  tsjq_res_if.source res
);

  dp_cmd_t  ctl;
  dp_stat_t stat;

  tsjq_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (cmd.valid),
    .in_kind  (cmd.kind),
    .in_ready (cmd.ready),
    .stat     (stat),
    .ctl      (ctl)
  );

  tsjq_dp #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .ctl           (ctl),
    .stat          (stat),
    .in_start      (cmd.start_time),
    .in_tag        (cmd.job_tag),
    .in_pos        (cmd.position),
    .out_valid     (res.valid),
    .out_ready     (res.ready),
    .status        (res.status),
    .out_tag       (res.out_tag),
    .out_start     (res.out_start),
    .out_submitted (res.out_submitted),
    .now_time      (res.now_time),
    .last          (res.last)
  );

endmodule

`default_nettype wire

// File: hdl/tsjq_ctrl.sv
// Controller FSM for the job queue: sequences add, remove and tick bursts.
// Depends on tsjq_pkg; drives the datapath through dp_cmd_t, reads dp_stat_t.
`timescale 1ns / 1ps
`default_nettype none

module tsjq_ctrl import tsjq_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  input  logic [KIND_W-1:0] in_kind,
  output logic              in_ready,
  input  dp_stat_t          stat,
  output dp_cmd_t           ctl
);

  state_t             state;
  state_t             state_next;
  logic [BURST_W-1:0] burst;
  logic [BURST_W-1:0] burst_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      burst <= '0;
    end else begin
      state <= state_next;
      burst <= burst_next;
    end
  end

  always_comb begin
    state_next    = state;
    burst_next    = burst;
    ctl           = '0;
    in_ready      = 1'b0;
    ctl.burst_end = (burst == BURST_W'(MAX_BURST - 1));
    unique case (state)
      S_IDLE: begin
        in_ready  = 1'b1;
        ctl.latch = in_valid;
        if (in_valid) begin
          unique case (in_kind)
            KIND_ADD:    state_next = S_ADD;
            KIND_REMOVE: state_next = S_REMOVE;
            KIND_TICK:   state_next = S_TICK;
            default:     state_next = S_IDLE;  // unused kind: dropped
          endcase
        end
      end
      S_ADD: begin
        if (stat.out_free) begin
          ctl.add    = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_REMOVE: begin
        if (stat.out_free) begin
          ctl.remove = 1'b1;
          state_next = S_IDLE;
        end
      end
      S_TICK: begin
        ctl.advance = 1'b1;
        burst_next  = '0;
        state_next  = S_SCAN;
      end
      S_SCAN: begin
        // only reached with nothing due on the first look; later exits go on last
        if (!stat.head_due) begin
          state_next = S_IDLE;
        end else if (stat.out_free) begin
          ctl.pop    = 1'b1;
          burst_next = burst + 1'b1;
          if (ctl.burst_end || !stat.next_due) begin
            state_next = S_IDLE;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

`default_nettype wire

// File: hdl/tsjq_dp.sv
// Datapath for the job queue: sorted shifting entry array, fill count, time
// counter, command capture and result register. Depends on tsjq_pkg.
`timescale 1ns / 1ps
`default_nettype none

module tsjq_dp import tsjq_pkg::*; #(
  parameter int QUEUE_DEPTH = DEPTH_DEFAULT,
  parameter int TIME_BITS   = TIME_BITS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst,
  input  dp_cmd_t             ctl,
  output dp_stat_t            stat,
  input  logic [START_W-1:0]  in_start,
  input  logic [TAG_W-1:0]    in_tag,
  input  logic [POS_W-1:0]    in_pos,
  output logic                out_valid,
  input  logic                out_ready,
  output logic [STATUS_W-1:0] status,
  output logic [TAG_W-1:0]    out_tag,
  output logic [START_W-1:0]  out_start,
  output logic [START_W-1:0]  out_submitted,
  output logic [START_W-1:0]  now_time,
  output logic                last
);

  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam int CMP_W = (CNT_W > POS_W) ? CNT_W : POS_W;

  // entry cells, kept sorted by start time; cells at or above fill are stale
  logic [TIME_BITS-1:0] slot_start          [QUEUE_DEPTH];
  logic [TAG_W-1:0]     slot_tag            [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] slot_submitted      [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] slot_start_next     [QUEUE_DEPTH];
  logic [TAG_W-1:0]     slot_tag_next       [QUEUE_DEPTH];
  logic [TIME_BITS-1:0] slot_submitted_next [QUEUE_DEPTH];

  logic [CNT_W-1:0]     fill;
  logic [TIME_BITS-1:0] clock_now;
  logic [TIME_BITS-1:0] st_q;
  logic [TAG_W-1:0]     tag_q;
  logic [POS_W-1:0]     pos_q;

  logic [QUEUE_DEPTH-1:0] le;
  logic                   full;
  logic                   empty;
  logic                   bad_pos;
  logic                   do_insert;
  logic                   do_take;
  logic                   load;
  logic [CMP_W-1:0]       rm_idx;
  logic [IDX_W-1:0]       rd_idx;

  logic [STATUS_W-1:0]    status_next;
  logic [TAG_W-1:0]       tag_next;
  logic [START_W-1:0]     start_next;
  logic [START_W-1:0]     submitted_next;
  logic                   last_next;

  always_ff @(posedge clk) begin
    if (ctl.latch) begin
      st_q  <= TIME_BITS'(in_start);
      tag_q <= in_tag;
      pos_q <= in_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clock_now <= '0;
    end else if (ctl.advance && (clock_now != '1)) begin
      clock_now <= clock_now + 1'b1;
    end
  end

  assign full      = (fill == CNT_W'(QUEUE_DEPTH));
  assign empty     = (fill == '0);
  assign bad_pos   = (CMP_W'(pos_q) >= CMP_W'(fill));
  assign do_insert = ctl.add && !full;
  assign do_take   = ctl.pop || (ctl.remove && !empty && !bad_pos);
  assign load      = ctl.add || ctl.remove || ctl.pop;
  assign rm_idx    = ctl.pop ? '0 : CMP_W'(pos_q);
  assign rd_idx    = IDX_W'(rm_idx);

  // Each cell decides locally: entries not later than the new start stay,
  // the first later one takes the new entry, the rest move down one place.
  // A take moves every cell at or after the index up one place.
  for (genvar g = 0; g < QUEUE_DEPTH; g++) begin : g_cell
    logic                 prev_le;
    logic [TIME_BITS-1:0] prev_start;
    logic [TAG_W-1:0]     prev_tag;
    logic [TIME_BITS-1:0] prev_sub;
    logic [TIME_BITS-1:0] nb_start;
    logic [TAG_W-1:0]     nb_tag;
    logic [TIME_BITS-1:0] nb_sub;

    assign le[g] = (CMP_W'(g) < CMP_W'(fill)) && (slot_start[g] <= st_q);

    if (g == 0) begin : g_head
      assign prev_le    = 1'b1;
      assign prev_start = st_q;
      assign prev_tag   = tag_q;
      assign prev_sub   = clock_now;
    end else begin : g_body
      assign prev_le    = le[g-1];
      assign prev_start = slot_start[g-1];
      assign prev_tag   = slot_tag[g-1];
      assign prev_sub   = slot_submitted[g-1];
    end

    if (g == QUEUE_DEPTH - 1) begin : g_tail
      assign nb_start = slot_start[g];
      assign nb_tag   = slot_tag[g];
      assign nb_sub   = slot_submitted[g];
    end else begin : g_inner
      assign nb_start = slot_start[g+1];
      assign nb_tag   = slot_tag[g+1];
      assign nb_sub   = slot_submitted[g+1];
    end

    always_comb begin
      slot_start_next[g]     = slot_start[g];
      slot_tag_next[g]       = slot_tag[g];
      slot_submitted_next[g] = slot_submitted[g];
      if (do_insert && !le[g]) begin
        if (prev_le) begin
          slot_start_next[g]     = st_q;
          slot_tag_next[g]       = tag_q;
          slot_submitted_next[g] = clock_now;
        end else begin
          slot_start_next[g]     = prev_start;
          slot_tag_next[g]       = prev_tag;
          slot_submitted_next[g] = prev_sub;
        end
      end else if (do_take && (CMP_W'(g) >= rm_idx)) begin
        slot_start_next[g]     = nb_start;
        slot_tag_next[g]       = nb_tag;
        slot_submitted_next[g] = nb_sub;
      end
    end
  end

  always_ff @(posedge clk) begin
    slot_start     <= slot_start_next;
    slot_tag       <= slot_tag_next;
    slot_submitted <= slot_submitted_next;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill <= '0;
    end else if (do_insert) begin
      fill <= fill + 1'b1;
    end else if (do_take) begin
      fill <= fill - 1'b1;
    end
  end

  always_comb begin
    status_next    = RES_ADDED;
    tag_next       = '0;
    start_next     = '0;
    submitted_next = '0;
    last_next      = 1'b1;
    priority if (ctl.add) begin
      if (full) begin
        status_next = RES_FULL;
      end else begin
        tag_next       = tag_q;
        start_next     = START_W'(st_q);
        submitted_next = START_W'(clock_now);
      end
    end else if (ctl.remove) begin
      if (empty) begin
        status_next = RES_EMPTY;
      end else if (bad_pos) begin
        status_next = RES_BAD_INDEX;
      end else begin
        status_next    = RES_REMOVED;
        tag_next       = slot_tag[rd_idx];
        start_next     = START_W'(slot_start[rd_idx]);
        submitted_next = START_W'(slot_submitted[rd_idx]);
      end
    end else begin
      status_next    = RES_DISPATCHED;
      tag_next       = slot_tag[rd_idx];
      start_next     = START_W'(slot_start[rd_idx]);
      submitted_next = START_W'(slot_submitted[rd_idx]);
      last_next      = ctl.burst_end || !stat.next_due;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      status        <= status_next;
      out_tag       <= tag_next;
      out_start     <= start_next;
      out_submitted <= submitted_next;
      now_time      <= START_W'(clock_now);
      last          <= last_next;
    end
  end

  assign stat.out_free = !out_valid || out_ready;
  assign stat.head_due = !empty && (slot_start[0] <= clock_now);
  assign stat.next_due = (fill >= CNT_W'(2)) && (slot_start[1] <= clock_now);

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= CNT_W'(QUEUE_DEPTH))
    else $error("fill count above queue depth");

  a_load_free: assert property (@(posedge clk) disable iff (rst)
    load |-> stat.out_free)
    else $error("result loaded while result register still held");

  a_pop_due: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> stat.head_due)
    else $error("head released before it was due");

  a_clock_hold: assert property (@(posedge clk) disable iff (rst)
    !ctl.advance |=> $stable(clock_now))
    else $error("time counter moved without a tick");

  a_take_count: assert property (@(posedge clk) disable iff (rst)
    do_take |=> (fill == $past(fill) - 1'b1))
    else $error("fill count not reduced after take");

endmodule

`default_nettype wire
